/* hw/rtl/lhc_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// LLC header classifier package
// Payload types, field codes and the SAP and unnumbered-command decoders.
// ----------------------------------------------------------------------------
package lhc_pkg;

	localparam int unsigned HdrBytes = 17;
	localparam int unsigned LastByte = 17;
	localparam logic [15:0] MaxLengthReset = 16'd1500;

	// Protocol codes of a service access point.
	localparam logic [3:0] PROTO_SNA     = 4'd0;
	localparam logic [3:0] PROTO_IP      = 4'd1;
	localparam logic [3:0] PROTO_3COM    = 4'd2;
	localparam logic [3:0] PROTO_SNAP    = 4'd3;
	localparam logic [3:0] PROTO_BANYAN  = 4'd4;
	localparam logic [3:0] PROTO_NOVELL  = 4'd5;
	localparam logic [3:0] PROTO_LANMGR  = 4'd6;
	localparam logic [3:0] PROTO_STP     = 4'd7;
	localparam logic [3:0] PROTO_NETBIOS = 4'd8;
	localparam logic [3:0] PROTO_UNKNOWN = 4'd9;

	// Frame kinds.
	localparam logic [2:0] KIND_INFO = 3'd0;
	localparam logic [2:0] KIND_RR   = 3'd1;
	localparam logic [2:0] KIND_U    = 3'd5;

	// Unnumbered command and response codes.
	localparam logic [4:0] UC_UA    = 5'd0;
	localparam logic [4:0] UC_DM    = 5'd1;
	localparam logic [4:0] UC_RD    = 5'd2;
	localparam logic [4:0] UC_RIM   = 5'd3;
	localparam logic [4:0] UC_FRMR  = 5'd4;
	localparam logic [4:0] UC_SNRM  = 5'd5;
	localparam logic [4:0] UC_SNRME = 5'd6;
	localparam logic [4:0] UC_SARM  = 5'd7;
	localparam logic [4:0] UC_SARME = 5'd8;
	localparam logic [4:0] UC_SABM  = 5'd9;
	localparam logic [4:0] UC_SABME = 5'd10;
	localparam logic [4:0] UC_SIM   = 5'd11;
	localparam logic [4:0] UC_DISC  = 5'd12;
	localparam logic [4:0] UC_UP    = 5'd13;
	localparam logic [4:0] UC_RSET  = 5'd14;
	localparam logic [4:0] UC_UI    = 5'd15;
	localparam logic [4:0] UC_XID   = 5'd16;
	localparam logic [4:0] UC_TEST  = 5'd17;
	localparam logic [4:0] UC_NONE  = 5'd18;

	localparam logic [7:0] SapMask  = 8'hFE;
	localparam logic [7:0] UCtlMask = 8'hEC;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       frame_start;
	} in_item_t;

	typedef struct packed {
		logic [47:0] dest_mac;
		logic [47:0] src_mac;
		logic [15:0] length_field;
		logic        dsap_group;
		logic [3:0]  dsap_protocol;
		logic        ssap_response;
		logic [3:0]  ssap_protocol;
		logic [2:0]  frame_kind;
		logic [6:0]  send_seq;
		logic [6:0]  recv_seq;
		logic        poll_final;
		logic [4:0]  unnumbered_code;
	} out_item_t;

	// Raw header of one accepted frame, as handed from front to back.
	typedef struct packed {
		logic [47:0] dest_mac;
		logic [47:0] src_mac;
		logic [15:0] length_field;
		logic [7:0]  dsap;
		logic [7:0]  ssap;
		logic [7:0]  ctrl;
		logic [7:0]  ctrl_ext;
	} hdr_t;

	function automatic logic [3:0] sap_protocol(input logic [7:0] sap);
		logic [3:0] code;
		unique case (sap & SapMask)
			8'h04:   code = PROTO_SNA;
			8'h06:   code = PROTO_IP;
			8'h80:   code = PROTO_3COM;
			8'hAA:   code = PROTO_SNAP;
			8'hBC:   code = PROTO_BANYAN;
			8'hE0:   code = PROTO_NOVELL;
			8'hFA:   code = PROTO_LANMGR;
			8'h42:   code = PROTO_STP;
			8'hF0:   code = PROTO_NETBIOS;
			default: code = PROTO_UNKNOWN;
		endcase
		return code;
	endfunction

	function automatic logic [4:0] u_code(input logic [7:0] ctrl, input logic pf,
			input logic resp);
		logic [7:0] m;
		logic [4:0] code;
		m = ctrl & UCtlMask;
		code = UC_NONE;
		if (pf && resp) begin
			unique case (m)
				8'h60:   code = UC_UA;
				8'h0C:   code = UC_DM;
				8'h40:   code = UC_RD;
				8'h04:   code = UC_RIM;
				8'h84:   code = UC_FRMR;
				default: code = UC_NONE;
			endcase
		end else if (pf) begin
			unique case (m)
				8'h80:   code = UC_SNRM;
				8'hCC:   code = UC_SNRME;
				8'h0C:   code = UC_SARM;
				8'h4C:   code = UC_SARME;
				8'h2C:   code = UC_SABM;
				8'h6C:   code = UC_SABME;
				8'h04:   code = UC_SIM;
				8'h40:   code = UC_DISC;
				8'h20:   code = UC_UP;
				8'h8C:   code = UC_RSET;
				default: code = UC_NONE;
			endcase
		end else begin
			unique case (m)
				8'h00:   code = UC_UI;
				8'hAC:   code = UC_XID;
				8'hE0:   code = UC_TEST;
				default: code = UC_NONE;
			endcase
		end
		return code;
	endfunction

endpackage
`default_nettype wire

/* hw/rtl/lhc_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// LLC header classifier front end
// Collects header bytes, applies the length filter and queues raw headers.
// ----------------------------------------------------------------------------
module lhc_front (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             accept,
	input  wire lhc_pkg::in_item_t item,
	input  wire logic             cfg_we,
	input  wire logic [15:0]      cfg_data,
	output logic                  hdr_push,
	output lhc_pkg::hdr_t         hdr_data
);
	import lhc_pkg::*;

	logic [15:0] max_length_q;
	logic [4:0]  byte_offset_q;
	logic        frame_active_q;
	logic [7:0]  hdr_q [HdrBytes];

	logic        eff_active;
	logic [4:0]  eff_offset;
	logic        storing;
	logic        at_last;
	logic [15:0] len;

	// A start marker restarts collection at byte 0 whatever came before.
	assign eff_active = item.frame_start | frame_active_q;
	assign eff_offset = item.frame_start ? 5'd0 : byte_offset_q;
	assign storing    = accept && eff_active && (eff_offset < 5'(HdrBytes));
	assign at_last    = accept && eff_active && (eff_offset == 5'(LastByte));
	assign len        = {hdr_q[12], hdr_q[13]};

	assign hdr_push = at_last && (len <= max_length_q);
	assign hdr_data = '{
		dest_mac:     {hdr_q[0], hdr_q[1], hdr_q[2], hdr_q[3], hdr_q[4], hdr_q[5]},
		src_mac:      {hdr_q[6], hdr_q[7], hdr_q[8], hdr_q[9], hdr_q[10], hdr_q[11]},
		length_field: len,
		dsap:         hdr_q[14],
		ssap:         hdr_q[15],
		ctrl:         hdr_q[16],
		ctrl_ext:     item.data_byte
	};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_length_q   <= MaxLengthReset;
			byte_offset_q  <= '0;
			frame_active_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				max_length_q <= cfg_data;
			end
			if (storing) begin
				byte_offset_q  <= eff_offset + 5'd1;
				frame_active_q <= 1'b1;
			end else if (at_last) begin
				byte_offset_q  <= '0;
				frame_active_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (storing) begin
			hdr_q[eff_offset] <= item.data_byte;
		end
	end

endmodule
`default_nettype wire

/* hw/rtl/lhc_hdr_fifo.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// LLC header classifier header queue
// Short register queue that decouples the front end from the decoder.
// ----------------------------------------------------------------------------
module lhc_hdr_fifo #(
	parameter int unsigned DEPTH = 2
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          wr_en,
	input  wire lhc_pkg::hdr_t wr_data,
	output logic               full,
	input  wire logic          rd_en,
	output logic               rd_valid,
	output lhc_pkg::hdr_t      rd_data
);
	import lhc_pkg::*;

	localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CntW = $clog2(DEPTH + 1);
	localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);

	hdr_t            mem_q [DEPTH];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;

	assign full     = (count_q == CntW'(DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + CntW'(1);
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - CntW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CntW'(DEPTH))
		else $error("header queue count exceeds its depth");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(wr_en && full))
		else $error("header queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> rd_valid)
		else $error("header queue read while empty");

	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en && !rd_en |=> count_q == $past(count_q) + CntW'(1))
		else $error("header queue count did not advance on a write");

endmodule
`default_nettype wire

/* hw/rtl/lhc_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// LLC header classifier back end
// Decodes a queued raw header into a result and holds it until popped.
// ----------------------------------------------------------------------------
module lhc_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          hdr_valid,
	input  wire lhc_pkg::hdr_t hdr,
	output logic               hdr_pop,
	input  wire logic          pop,
	output logic               empty,
	output lhc_pkg::out_item_t result
);
	import lhc_pkg::*;

	logic      out_valid_q;
	out_item_t result_q;
	out_item_t dec;
	logic      load;

	always_comb begin
		dec = '{
			dest_mac:        hdr.dest_mac,
			src_mac:         hdr.src_mac,
			length_field:    hdr.length_field,
			dsap_group:      hdr.dsap[0],
			dsap_protocol:   sap_protocol(hdr.dsap),
			ssap_response:   hdr.ssap[0],
			ssap_protocol:   sap_protocol(hdr.ssap),
			frame_kind:      KIND_INFO,
			send_seq:        '0,
			recv_seq:        hdr.ctrl_ext[7:1],
			poll_final:      hdr.ctrl_ext[0],
			unnumbered_code: UC_NONE
		};
		if (hdr.ctrl[1:0] == 2'b11) begin
			dec.frame_kind      = KIND_U;
			dec.recv_seq        = '0;
			dec.poll_final      = hdr.ctrl[4];
			dec.unnumbered_code = u_code(hdr.ctrl, hdr.ctrl[4], hdr.ssap[0]);
		end else if (!hdr.ctrl[0]) begin
			dec.send_seq = hdr.ctrl[7:1];
		end else begin
			// Supervisory kinds follow RR in the order of the two function bits.
			dec.frame_kind = KIND_RR + {1'b0, hdr.ctrl[3:2]};
		end
	end

	// The output register refills in the same cycle its transaction completes.
	assign load    = hdr_valid && (!out_valid_q || pop);
	assign hdr_pop = load;
	assign empty   = !out_valid_q;
	assign result  = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			result_q <= dec;
		end
	end

endmodule
`default_nettype wire

/* hw/rtl/llc_header_classifier_core.sv */
// A result passes from the transaction of frame byte 17 through the header queue and then the
// output register, where it can be popped.
// Throughput: one frame byte per cycle while not stalled; at most one result per frame of 18 or
// more bytes. The input stalls only when the header queue between the front end and the decoder
// is full.
// Reset clears the queues and the frame state and sets max_length to 1500.
`default_nettype none
// ----------------------------------------------------------------------------
// LLC header classifier
// Decodes the 802.3 MAC header and 802.2 LLC header of a byte stream.
// ----------------------------------------------------------------------------
module llc_header_classifier_core #(
	parameter int unsigned QUEUE_DEPTH = 2
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	output logic                    full,
	input  wire lhc_pkg::in_item_t  item,
	output logic                    empty,
	input  wire logic               pop,
	output lhc_pkg::out_item_t      result,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [15:0]        cfg_data
);
	import lhc_pkg::*;

	logic accept;
	logic hdr_push;
	hdr_t hdr_wr;
	logic hdr_pop;
	logic hdr_valid;
	hdr_t hdr_rd;

	assign accept    = push && !full;
	assign cfg_ready = 1'b1;

	lhc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.item     (item),
		.cfg_we   (cfg_valid && cfg_ready),
		.cfg_data (cfg_data),
		.hdr_push (hdr_push),
		.hdr_data (hdr_wr)
	);

	lhc_hdr_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (hdr_push),
		.wr_data  (hdr_wr),
		.full     (full),
		.rd_en    (hdr_pop),
		.rd_valid (hdr_valid),
		.rd_data  (hdr_rd)
	);

	lhc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.hdr_valid (hdr_valid),
		.hdr       (hdr_rd),
		.hdr_pop   (hdr_pop),
		.pop       (pop),
		.empty     (empty),
		.result    (result)
	);

endmodule
`default_nettype wire
